@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the shaper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("shaper assertion failed");

// next-cycle implication
`define ACS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("shaper assertion failed");

`endif

@@ hdl/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// acs_pkg
// Types, constants and form tables for the Arabic contextual shaper.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam logic [15:0] LETTER_FIRST = 16'h0621;
  localparam logic [15:0] LETTER_LAST  = 16'h064A;
  localparam logic [15:0] TATWEEL      = 16'h0640;
  localparam logic [15:0] LAM          = 16'h0644;
  localparam logic [15:0] LIG_MADDA    = 16'hFEF5;
  localparam logic [15:0] LIG_HAMZA_AB = 16'hFEF7;
  localparam logic [15:0] LIG_HAMZA_BL = 16'hFEF9;
  localparam logic [15:0] LIG_ALEF     = 16'hFEFB;
  localparam logic [15:0] MADDA_ALEF   = 16'h0622;
  localparam logic [15:0] ALEF_HAMZA_A = 16'h0623;
  localparam logic [15:0] ALEF_HAMZA_B = 16'h0625;
  localparam logic [15:0] ALEF         = 16'h0627;

  // classified request passed from front to back
  typedef struct packed {
    logic [15:0] code;
    logic        eot;
    logic        is_mark;
    logic        is_letter;
    logic        is_alef;
    logic        jb;
    logic        ja;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_MARKS,
    S_CUR,
    S_TAIL
  } state_t;

  // {isolated, initial, medial, final}
  function automatic logic [63:0] form_row(input logic [5:0] idx);
    logic [63:0] r;
    case (idx)
      6'd0:  r = {16'hFE80, 16'h0000, 16'h0000, 16'h0000};
      6'd1:  r = {16'hFE81, 16'h0000, 16'h0000, 16'hFE82};
      6'd2:  r = {16'hFE83, 16'h0000, 16'h0000, 16'hFE84};
      6'd3:  r = {16'hFE85, 16'h0000, 16'h0000, 16'hFE86};
      6'd4:  r = {16'hFE87, 16'h0000, 16'h0000, 16'hFE88};
      6'd5:  r = {16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
      6'd6:  r = {16'hFE8D, 16'h0000, 16'h0000, 16'hFE8E};
      6'd7:  r = {16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
      6'd8:  r = {16'hFE93, 16'h0000, 16'h0000, 16'hFE94};
      6'd9:  r = {16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
      6'd10: r = {16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
      6'd11: r = {16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
      6'd12: r = {16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
      6'd13: r = {16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
      6'd14: r = {16'hFEA9, 16'h0000, 16'h0000, 16'hFEAA};
      6'd15: r = {16'hFEAB, 16'h0000, 16'h0000, 16'hFEAC};
      6'd16: r = {16'hFEAD, 16'h0000, 16'h0000, 16'hFEAE};
      6'd17: r = {16'hFEAF, 16'h0000, 16'h0000, 16'hFEB0};
      6'd18: r = {16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
      6'd19: r = {16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
      6'd20: r = {16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
      6'd21: r = {16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
      6'd22: r = {16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
      6'd23: r = {16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
      6'd24: r = {16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
      6'd25: r = {16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
      6'd31: r = {16'h0640, 16'h0000, 16'h0000, 16'h0000};
      6'd32: r = {16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
      6'd33: r = {16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
      6'd34: r = {16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
      6'd35: r = {16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
      6'd36: r = {16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
      6'd37: r = {16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
      6'd38: r = {16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
      6'd39: r = {16'hFEED, 16'h0000, 16'h0000, 16'hFEEE};
      6'd40: r = {16'hFEEF, 16'h0000, 16'h0000, 16'hFEF0};
      6'd41: r = {16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
      default: r = 64'h0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [15:0] c);
    return (c >= LETTER_FIRST) && (c <= LETTER_LAST);
  endfunction

  function automatic logic [5:0] letter_idx(input logic [15:0] c);
    logic [15:0] d;
    d = c - LETTER_FIRST;
    return d[5:0];
  endfunction

  function automatic logic is_mark(input logic [15:0] c);
    return c inside {[16'h064B:16'h0655], 16'h0670, [16'h06D6:16'h06DC],
                     [16'h06DF:16'h06E4], 16'h06E7, 16'h06E8, [16'h06EA:16'h06ED]};
  endfunction

  function automatic logic joins_after(input logic [15:0] c);
    logic [63:0] r;
    r = form_row(letter_idx(c));
    if (c == TATWEEL) return 1'b1;
    if (!is_letter(c)) return 1'b0;
    return (r[47:32] != 16'h0) || (r[31:16] != 16'h0);
  endfunction

  function automatic logic joins_before(input logic [15:0] c);
    logic [63:0] r;
    r = form_row(letter_idx(c));
    if (c == TATWEEL) return 1'b1;
    if (!is_letter(c)) return 1'b0;
    return (r[31:16] != 16'h0) || (r[15:0] != 16'h0);
  endfunction

  function automatic logic is_alef(input logic [15:0] c);
    return c inside {MADDA_ALEF, ALEF_HAMZA_A, ALEF_HAMZA_B, ALEF};
  endfunction

  function automatic logic [15:0] shape(input logic [15:0] c, input logic jb,
                                        input logic ja);
    logic [63:0] r;
    r = form_row(letter_idx(c));
    if (!is_letter(c) || (c == TATWEEL)) return c;
    if (jb && ja && (r[31:16] != 16'h0)) return r[31:16];
    if (jb && (r[15:0] != 16'h0)) return r[15:0];
    if (ja && (r[47:32] != 16'h0)) return r[47:32];
    if (r[63:48] != 16'h0) return r[63:48];
    return c;
  endfunction

  function automatic logic [15:0] ligature(input logic [15:0] alef_c,
                                           input logic fin);
    logic [15:0] iso;
    case (alef_c)
      MADDA_ALEF:   iso = LIG_MADDA;
      ALEF_HAMZA_A: iso = LIG_HAMZA_AB;
      ALEF_HAMZA_B: iso = LIG_HAMZA_BL;
      default:      iso = LIG_ALEF;
    endcase
    return iso + {15'd0, fin};
  endfunction

endpackage

@@ hdl/acs_if.sv @@
// ----------------------------------------------------------------------------
// Shaper channel interfaces
// Valid/ready channels for code units in and shaped units out.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_text;

  modport source (output valid, code_unit, end_of_text, input ready);
  modport sink   (input valid, code_unit, end_of_text, output ready);
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] shaped_unit;
  logic        last_of_run;
  logic        text_done;
  logic        mark_overflow;

  modport source (output valid, shaped_unit, last_of_run, text_done, mark_overflow,
                  input ready);
  modport sink   (input valid, shaped_unit, last_of_run, text_done, mark_overflow,
                  output ready);
endinterface

@@ hdl/acs_fifo.sv @@
// ----------------------------------------------------------------------------
// acs_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module acs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  acs_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output acs_pkg::item_t rd_item
);

  acs_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

@@ hdl/acs_front.sv @@
// ----------------------------------------------------------------------------
// acs_front
// Accepts code units and classifies them (mark, letter, alef, joining).
// ----------------------------------------------------------------------------
module acs_front (
  acs_in_if.sink         in_ch,
  output logic           q_valid,
  input  logic           q_ready,
  output acs_pkg::item_t q_item
);

  always_comb begin
    q_item.code      = in_ch.code_unit;
    q_item.eot       = in_ch.end_of_text;
    q_item.is_mark   = acs_pkg::is_mark(in_ch.code_unit);
    q_item.is_letter = acs_pkg::is_letter(in_ch.code_unit);
    q_item.is_alef   = acs_pkg::is_alef(in_ch.code_unit);
    q_item.jb        = acs_pkg::joins_before(in_ch.code_unit);
    q_item.ja        = acs_pkg::joins_after(in_ch.code_unit);
  end

  assign q_valid     = in_ch.valid;
  assign in_ch.ready = q_ready;

endmodule

@@ hdl/acs_back.sv @@
// ----------------------------------------------------------------------------
// acs_back
// Shaping sequencer: holds the pending letter and its marks, emits results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acs_back #(
  parameter int MARK_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  acs_pkg::item_t q_item,
  acs_out_if.source      out_ch
);

  localparam int CNT_W = $clog2(MARK_DEPTH + 1);
  localparam int IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MARK_DEPTH);

  acs_pkg::state_t state_r, state_nxt;

  logic [15:0]      pend_letter_r, pend_letter_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             pend_jb_r, pend_jb_nxt;
  logic             lbja_r, lbja_nxt;
  logic [CNT_W-1:0] mark_cnt_r, mark_cnt_nxt;
  logic [15:0]      mark_q [MARK_DEPTH];
  logic             mark_wr;

  // plan for the request being worked off
  logic [15:0]      head_r, head_nxt;
  logic             head_ovf_r, head_ovf_nxt;
  logic             cur_r, cur_nxt;
  logic             tail_r, tail_nxt;
  logic [15:0]      tail_val_r, tail_val_nxt;
  logic [15:0]      code_r, code_nxt;
  logic             eot_r, eot_nxt;
  logic [CNT_W-1:0] drain_n_r, drain_n_nxt;
  logic [CNT_W-1:0] drain_i_r, drain_i_nxt;

  logic             ov_r;
  logic [15:0]      o_unit_r;
  logic             o_last_r, o_done_r, o_ovf_r;

  logic             slot, pop;
  logic             em_en, em_last, em_ovf;
  logic [15:0]      em_unit;
  logic             p_flush, p_ovf, p_cur, p_tail;
  logic [15:0]      p_head, p_tail_val;
  logic [CNT_W-1:0] p_dn;
  logic [CNT_W-1:0] drain_i_inc;

  assign slot        = !ov_r || out_ch.ready;
  assign q_ready     = (state_r == acs_pkg::S_IDLE);
  assign pop         = q_valid && q_ready;
  assign drain_i_inc = drain_i_r + CNT_W'(1);

  // plan of a newly popped request and the state it leaves behind
  always_comb begin
    p_flush         = 1'b0;
    p_head          = 16'h0;
    p_ovf           = 1'b0;
    p_cur           = 1'b0;
    p_tail          = 1'b0;
    p_tail_val      = 16'h0;
    p_dn            = '0;
    mark_wr         = 1'b0;
    pend_letter_nxt = pend_letter_r;
    pend_valid_nxt  = pend_valid_r;
    pend_jb_nxt     = pend_jb_r;
    lbja_nxt        = lbja_r;
    mark_cnt_nxt    = mark_cnt_r;
    if (pop) begin
      if (q_item.is_mark) begin
        if (!pend_valid_r) begin
          p_cur = 1'b1;
        end else if (mark_cnt_r < DEPTH_C) begin
          mark_wr      = 1'b1;
          mark_cnt_nxt = mark_cnt_r + CNT_W'(1);
          if (q_item.eot) begin
            p_flush        = 1'b1;
            p_head         = acs_pkg::shape(pend_letter_r, pend_jb_r, 1'b0);
            p_dn           = mark_cnt_r + CNT_W'(1);
            pend_valid_nxt = 1'b0;
            mark_cnt_nxt   = '0;
          end
        end else begin
          p_flush        = 1'b1;
          p_ovf          = 1'b1;
          p_head         = acs_pkg::shape(pend_letter_r, pend_jb_r, 1'b0);
          p_dn           = mark_cnt_r;
          p_cur          = 1'b1;
          pend_valid_nxt = 1'b0;
          mark_cnt_nxt   = '0;
          lbja_nxt       = 1'b0;
        end
      end else begin
        if (pend_valid_r) begin
          p_flush        = 1'b1;
          p_dn           = mark_cnt_r;
          pend_valid_nxt = 1'b0;
          mark_cnt_nxt   = '0;
          if ((pend_letter_r == acs_pkg::LAM) && q_item.is_alef) begin
            p_head = acs_pkg::ligature(q_item.code, pend_jb_r);
          end else begin
            p_head = acs_pkg::shape(pend_letter_r, pend_jb_r, q_item.jb);
          end
        end
        if (pend_valid_r && (pend_letter_r == acs_pkg::LAM) && q_item.is_alef) begin
          lbja_nxt = 1'b0;  // alef consumed into the ligature
        end else begin
          lbja_nxt = q_item.ja;
          if (q_item.is_letter) begin
            pend_letter_nxt = q_item.code;
            pend_valid_nxt  = 1'b1;
            pend_jb_nxt     = lbja_r;
            mark_cnt_nxt    = '0;
            if (q_item.eot) begin
              p_tail         = 1'b1;
              p_tail_val     = acs_pkg::shape(q_item.code, lbja_r, 1'b0);
              pend_valid_nxt = 1'b0;
            end
          end else begin
            p_cur = 1'b1;
          end
        end
      end
      if (q_item.eot) lbja_nxt = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    head_ovf_nxt = head_ovf_r;
    cur_nxt      = cur_r;
    tail_nxt     = tail_r;
    tail_val_nxt = tail_val_r;
    code_nxt     = code_r;
    eot_nxt      = eot_r;
    drain_n_nxt  = drain_n_r;
    drain_i_nxt  = drain_i_r;
    em_en        = 1'b0;
    em_unit      = 16'h0;
    em_last      = 1'b0;
    em_ovf       = 1'b0;
    case (state_r)
      acs_pkg::S_IDLE: begin
        if (pop) begin
          head_nxt     = p_head;
          head_ovf_nxt = p_ovf;
          cur_nxt      = p_cur;
          tail_nxt     = p_tail;
          tail_val_nxt = p_tail_val;
          code_nxt     = q_item.code;
          eot_nxt      = q_item.eot;
          drain_n_nxt  = p_dn;
          drain_i_nxt  = '0;
          if (p_flush)     state_nxt = acs_pkg::S_HEAD;
          else if (p_cur)  state_nxt = acs_pkg::S_CUR;
          else if (p_tail) state_nxt = acs_pkg::S_TAIL;
        end
      end
      acs_pkg::S_HEAD: begin
        if (slot) begin
          em_en   = 1'b1;
          em_unit = head_r;
          em_ovf  = head_ovf_r;
          em_last = (drain_n_r == '0) && !cur_r && !tail_r;
          if (drain_n_r != '0) state_nxt = acs_pkg::S_MARKS;
          else if (cur_r)      state_nxt = acs_pkg::S_CUR;
          else if (tail_r)     state_nxt = acs_pkg::S_TAIL;
          else                 state_nxt = acs_pkg::S_IDLE;
        end
      end
      acs_pkg::S_MARKS: begin
        if (slot) begin
          em_en       = 1'b1;
          em_unit     = mark_q[drain_i_r[IDX_W-1:0]];
          em_last     = (drain_i_inc == drain_n_r) && !cur_r && !tail_r;
          drain_i_nxt = drain_i_inc;
          if (drain_i_inc == drain_n_r) begin
            if (cur_r)       state_nxt = acs_pkg::S_CUR;
            else if (tail_r) state_nxt = acs_pkg::S_TAIL;
            else             state_nxt = acs_pkg::S_IDLE;
          end
        end
      end
      acs_pkg::S_CUR: begin
        if (slot) begin
          em_en     = 1'b1;
          em_unit   = code_r;
          em_last   = !tail_r;
          state_nxt = tail_r ? acs_pkg::S_TAIL : acs_pkg::S_IDLE;
        end
      end
      acs_pkg::S_TAIL: begin
        if (slot) begin
          em_en     = 1'b1;
          em_unit   = tail_val_r;
          em_last   = 1'b1;
          state_nxt = acs_pkg::S_IDLE;
        end
      end
      default: state_nxt = acs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= acs_pkg::S_IDLE;
      pend_letter_r <= 16'h0;
      pend_valid_r  <= 1'b0;
      pend_jb_r     <= 1'b0;
      lbja_r        <= 1'b0;
      mark_cnt_r    <= '0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pend_letter_r <= pend_letter_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_jb_r     <= pend_jb_nxt;
      lbja_r        <= lbja_nxt;
      mark_cnt_r    <= mark_cnt_nxt;
      if (em_en)             ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    head_ovf_r <= head_ovf_nxt;
    cur_r      <= cur_nxt;
    tail_r     <= tail_nxt;
    tail_val_r <= tail_val_nxt;
    code_r     <= code_nxt;
    eot_r      <= eot_nxt;
    drain_n_r  <= drain_n_nxt;
    drain_i_r  <= drain_i_nxt;
    if (mark_wr) mark_q[mark_cnt_r[IDX_W-1:0]] <= q_item.code;
    if (em_en) begin
      o_unit_r <= em_unit;
      o_last_r <= em_last;
      o_done_r <= em_last && eot_r;
      o_ovf_r  <= em_ovf;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.shaped_unit   = o_unit_r;
  assign out_ch.last_of_run   = o_last_r;
  assign out_ch.text_done     = o_done_r;
  assign out_ch.mark_overflow = o_ovf_r;

  `ACS_ASSERT_IMP(a_drain_in_range, clk, rst_n, state_r == acs_pkg::S_MARKS, drain_i_r < drain_n_r)
  `ACS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, mark_cnt_r <= DEPTH_C)
  `ACS_ASSERT_IMP(a_no_marks_idle, clk, rst_n, !pend_valid_r, mark_cnt_r == '0)
  `ACS_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, em_en, ov_r)

endmodule

@@ hdl/arabic_contextual_shaper_top.sv @@
// ----------------------------------------------------------------------------
// arabic_contextual_shaper_top
// Streaming Arabic contextual shaper (presentation forms B, lam-alef).
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  in_ch   | in  | code_unit[15:0], end_of_text                     | valid/ready
//  out_ch  | out | shaped_unit[15:0], last_of_run, text_done,       | valid/ready
//          |     | mark_overflow                                    |
//
//  The back sequencer pops a request, then emits its results one by one
//  (flushed letter, held marks, passed unit, final letter); it pops the
//  next request only when idle. A request that yields nothing is only popped.
//  Single output register in the back: one result a cycle while out_ch ready.
//  rst_n is synchronous, active low: clears pending letter, mark count, queue.
//  A stalled out_ch holds the back; the two-entry queue keeps in_ch open until full.
// ----------------------------------------------------------------------------
module arabic_contextual_shaper_top #(
  parameter int MARK_DEPTH = 8
) (
  input logic       clk,
  input logic       rst_n,
  acs_in_if.sink    in_ch,
  acs_out_if.source out_ch
);

  logic           fq_valid, fq_ready;
  acs_pkg::item_t fq_item;
  logic           qb_valid, qb_ready;
  acs_pkg::item_t qb_item;

  // classify incoming code units
  acs_front u_front (
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  // decouples acceptance from result draining
  acs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  // pending letter, mark store, shaping and result sequencing
  acs_back #(
    .MARK_DEPTH (MARK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_item  (qb_item),
    .out_ch  (out_ch)
  );

endmodule
